### hw/rtl/matrix_multiply_dot_engine_macros.svh
// ----------------------------------------------------------------------------
// matrix multiply dot engine assertion macros
// shared property forms for the concurrent checks of the engine
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_DOT_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_DOT_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MMDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MMDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mmde_pkg.sv
// ----------------------------------------------------------------------------
// mmde_pkg
// shared codes, widths and control types of the matrix multiply dot engine
// ----------------------------------------------------------------------------
package mmde_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 4;
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int SUM_W   = 35;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // per-cell control group
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd;
    } cell_ctl_t;

endpackage

### hw/rtl/mmde_cell.sv
// ----------------------------------------------------------------------------
// mmde_cell
// one term of the dot product: holds column k of A and row k of B,
// multiplies the selected pair and adds it onto the partial sum from
// the previous cell
// ----------------------------------------------------------------------------
module mmde_cell
    import mmde_pkg::*;
#(
    parameter int DIM   = 16,
    parameter int ACC_W = 37
)
(
    input  logic                           clk,
    input  cell_ctl_t                      ctl,
    input  logic [$clog2(DIM)-1:0]         a_addr,
    input  logic [$clog2(DIM)-1:0]         b_addr,
    input  logic signed [VALUE_W-1:0]      wdata,
    input  logic signed [ACC_W-1:0]        sum_in,
    output logic signed [ACC_W-1:0]        sum_out
);

    // a_mem[r] = A[r][k], b_mem[c] = B[k][c]
    logic signed [VALUE_W-1:0] a_mem [DIM];
    logic signed [VALUE_W-1:0] b_mem [DIM];

    logic signed [VALUE_W-1:0] a_q_reg;
    logic signed [VALUE_W-1:0] b_q_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   sum_reg;
    logic signed [ACC_W-1:0]   sum_next;

    // element stores with registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_a)
        begin
            a_mem[a_addr] <= wdata;
        end
        if (ctl.wr_b)
        begin
            b_mem[b_addr] <= wdata;
        end
        if (ctl.rd)
        begin
            a_q_reg <= a_mem[a_addr];
            b_q_reg <= b_mem[b_addr];
        end
    end

    // partial sum grows by this cell's product
    always_comb
    begin
        sum_next = sum_in + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    // product and partial sum registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a_q_reg) * PROD_W'(b_q_reg);
        sum_reg  <= sum_next;
    end

    assign sum_out = sum_reg;

endmodule

### hw/rtl/matrix_multiply_dot_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_dot_engine
// square matrix multiply C = A*B over stored Q1.15 elements, one C element
// per request, built as a chain of multiply-add cells
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A write beat (cmd 0 or
// 1) stores one element; busy stays low. A compute beat (cmd 2) raises busy
// while the request runs through the cell chain: every cell reads its
// element pair at the request beat, the product registers form the
// products, the partial sum ripples through the chain one cell per cycle,
// and the result register takes the saturated sum. The saturated Q5.30 sum
// shows on product_sum with done high for exactly one cycle, rising at the
// edge where busy falls; a new beat may be taken in that same cycle. The
// receiver cannot stall, so done must be captured when it is high. Elements
// must be written before a request reads them; a request with row or col at
// DIM or above returns zero, and cmd 3 is ignored.
// ----------------------------------------------------------------------------
`include "matrix_multiply_dot_engine_macros.svh"

module matrix_multiply_dot_engine
    import mmde_pkg::*;
#(
    parameter int DIM = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [ROW_W-1:0]          row,
    input  logic [ROW_W-1:0]          col,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      done,
    output logic signed [SUM_W-1:0]   product_sum
);

    localparam int IDX_W  = $clog2(DIM);
    localparam int XW     = (IDX_W > ROW_W) ? IDX_W : ROW_W;
    localparam int ACC_MIN = 36;
    localparam int ACC_W  = (PROD_W + 1 + $clog2(DIM) > ACC_MIN) ?
                            (PROD_W + 1 + $clog2(DIM)) : ACC_MIN;
    localparam int CNT_W  = $clog2(DIM + 2);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIM + 1);
    localparam logic [XW:0]      DIM_X = (XW+1)'(DIM);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               in_range_reg;
    logic               in_range_next;
    logic               done_reg;
    logic               done_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    logic               accept;
    logic               in_range;
    logic [XW-1:0]      row_x;
    logic [XW-1:0]      col_x;
    logic [IDX_W-1:0]   row_addr;
    logic [IDX_W-1:0]   col_addr;
    logic signed [ACC_W-1:0] chain [DIM+1];
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-SUM_W:0]    acc_hi;
    logic signed [SUM_W-1:0] acc_sat;

    // input beat decode and index range check
    assign accept   = start && !busy;
    assign row_x    = XW'(row);
    assign col_x    = XW'(col);
    assign row_addr = row_x[IDX_W-1:0];
    assign col_addr = col_x[IDX_W-1:0];
    assign in_range = ({1'b0, row_x} < DIM_X) && ({1'b0, col_x} < DIM_X);

    // cell chain, seeded with zero
    assign chain[0] = '0;

    for (genvar k = 0; k < DIM; k++)
    begin : g_cell
        cell_ctl_t ctl;

        // A[r][c] lives in cell c, B[r][c] in cell r
        always_comb
        begin
            ctl.wr_a = accept && (cmd == CMD_WRITE_A) && in_range && (col_x == XW'(k));
            ctl.wr_b = accept && (cmd == CMD_WRITE_B) && in_range && (row_x == XW'(k));
            ctl.rd   = accept && (cmd == CMD_COMPUTE);
        end

        mmde_cell #(
            .DIM   (DIM),
            .ACC_W (ACC_W)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .a_addr  (row_addr),
            .b_addr  (col_addr),
            .wdata   (value),
            .sum_in  (chain[k]),
            .sum_out (chain[k+1])
        );
    end

    // saturate the full sum to the result range
    assign acc    = chain[DIM];
    assign acc_hi = acc[ACC_W-1:SUM_W-1];

    always_comb
    begin
        if ((&acc_hi) || !(|acc_hi))
        begin
            acc_sat = acc[SUM_W-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    // request sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_range_next = in_range_reg;
        done_next     = 1'b0;
        sum_next      = sum_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_COMPUTE))
                begin
                    state_next    = ST_BUSY;
                    cnt_next      = '0;
                    in_range_next = in_range;
                end
            end
            ST_BUSY:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    sum_next   = in_range_reg ? acc_sat : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            in_range_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            in_range_reg <= in_range_next;
            done_reg     <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign busy        = (state_reg == ST_BUSY);
    assign done        = done_reg;
    assign product_sum = sum_reg;

    // checks
    `MMDE_ASSERT_NEXT(a_done_after_chain, clk, rst_n, busy && (cnt_reg == LAST), done && !busy, "result beat missing after the sum chain settled")
    `MMDE_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy, "result beat while a request is in flight")
    `MMDE_ASSERT_NEXT(a_compute_starts, clk, rst_n, accept && (cmd == CMD_COMPUTE), busy && (cnt_reg == '0), "request beat did not start the sequencer")
    `MMDE_ASSERT_NEXT(a_write_no_result, clk, rst_n, accept && (cmd != CMD_COMPUTE), !busy && !done, "non-request beat started work or gave a result")

endmodule
